>>> rtl/imp_pkg.sv
package imp_pkg;

  localparam int IMP_RPM_ROWS      = 43;
  localparam int IMP_THROTTLE_COLS = 10;

  localparam int MODE_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = 10;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 4;
  localparam int HOLD_W   = 17;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 20;
  localparam int MIN_W     = 12;
  localparam int STEP_W    = 16;
  localparam int RATE_W    = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_RATE = 2'd2;

  localparam logic [MIN_W-1:0]  MIN_SAMPLE_RST   = 12'd0;
  localparam logic [STEP_W-1:0] RPM_STEP_RST     = 16'd250;
  localparam logic [RATE_W-1:0] CAPTURE_RATE_RST = 20'd10000;

  // rpm = (rate / period) * 120; column = (sample - min) * 3 / 800
  localparam int RPM_SCALE = 120;
  localparam int COL_SCALE = 3;
  localparam int COL_DIV   = 800;
  localparam int RPM_W     = 27;
  localparam int PROD_W    = 18;

  localparam int DIV_DW = 20;
  localparam int DIV_VW = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_RISE     = 3'd0,
    MODE_FALL     = 3'd1,
    MODE_TICK     = 3'd2,
    MODE_CTRL     = 3'd3,
    MODE_WRITE    = 3'd4,
    MODE_READ_COR = 3'd5,
    MODE_READ_LOG = 3'd6,
    MODE_COPY     = 3'd7
  } mode_t;

  typedef struct packed {
    logic log_we;
    logic log_re;
    logic cor_we;
    logic cor_re;
  } tbl_ctl_t;

endpackage

>>> rtl/imp_div.sv
module imp_div import imp_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;

  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          fits;
  logic [VW-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    fits    = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = fits ? diff[VW-1:0] : shifted[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/imp_tables.sv
module imp_tables import imp_pkg::*; #(
  parameter int DEPTH = IMP_RPM_ROWS * IMP_THROTTLE_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  tbl_ctl_t            ctl,
  input  logic [AW-1:0]       log_waddr,
  input  logic [SAMPLE_W-1:0] log_wdata,
  input  logic [AW-1:0]       log_raddr,
  output logic [SAMPLE_W-1:0] log_rdata,
  input  logic [AW-1:0]       cor_waddr,
  input  logic [SAMPLE_W-1:0] cor_wdata,
  input  logic [AW-1:0]       cor_raddr,
  output logic [SAMPLE_W-1:0] cor_rdata
);

  logic [SAMPLE_W-1:0] log_mem [DEPTH];
  logic [SAMPLE_W-1:0] cor_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.log_we) begin
      log_mem[log_waddr] <= log_wdata;
    end
    if (ctl.log_re) begin
      log_rdata <= log_mem[log_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cor_we) begin
      cor_mem[cor_waddr] <= cor_wdata;
    end
    if (ctl.cor_re) begin
      cor_rdata <= cor_mem[cor_raddr];
    end
  end

endmodule

>>> rtl/injector_map_pulse_controller.sv
// Injector pulse controller with an rpm-by-throttle correction map.
// Input channel (in_valid / in_stall): one beat per event: rise edge, fall
// edge, timer tick, control step, table write, table reads, log copy.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// in order, carrying the injector level, hold status, current cell and
// correction, read data and an index error flag.
// Items are handled one at a time. Edges, ticks, writes and out-of-range
// accesses pass through EXEC and FINISH, table reads through EXEC, MEMRD and
// FINISH; the next beat can be taken in the cycle after the result is loaded.
// A control step makes two passes through one shared restoring divider (rate
// / period, then rpm / rpm_step), then does a log write and correction read;
// the second pass is skipped if the rpm overflows, and both if period or
// step is zero. A copy sweeps the log memory into the correction memory.
// After rst_n the two table memories are cleared one entry per cycle, with
// in_stall high; config writes are taken during that pass. A finished
// result sits in the output register while out_stall is high; the next
// input beat is still taken and worked on, and its result waits until the
// output register frees.
module injector_map_pulse_controller import imp_pkg::*; #(
  parameter int RPM_ROWS      = IMP_RPM_ROWS,
  parameter int THROTTLE_COLS = IMP_THROTTLE_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [ENTRY_W-1:0]   in_entry_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_injector_on,
  output logic                 out_override_active,
  output logic [ROW_W-1:0]     out_rpm_row,
  output logic [COL_W-1:0]     out_throttle_col,
  output logic [SAMPLE_W-1:0]  out_correction_now,
  output logic [SAMPLE_W-1:0]  out_read_data,
  output logic                 out_index_error
);

  localparam int TABLE_SIZE = RPM_ROWS * THROTTLE_COLS;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_EXEC   = 10'b00_0000_0100,
    ST_DIV1   = 10'b00_0000_1000,
    ST_DIV2   = 10'b00_0001_0000,
    ST_CELL   = 10'b00_0010_0000,
    ST_COR    = 10'b00_0100_0000,
    ST_MEMRD  = 10'b00_1000_0000,
    ST_COPY   = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                copy_wr_r;
  logic [IDX_W-1:0]    copy_wa_r;

  mode_t               mode_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [ENTRY_W-1:0]  index_r;

  logic [MIN_W-1:0]    min_sample_r;
  logic [STEP_W-1:0]   rpm_step_r;
  logic [RATE_W-1:0]   capture_rate_r;

  logic [SAMPLE_W-1:0] last_period_r;
  logic [SAMPLE_W-1:0] last_pulse_r;
  logic [SAMPLE_W-1:0] cor_r;
  logic [HOLD_W-1:0]   hold_cnt_r;
  logic                hold_r;
  logic                drive_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                idx_err_r;

  logic                out_valid_r;
  logic                out_on_r;
  logic                out_hold_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [SAMPLE_W-1:0] out_cor_r;
  logic [SAMPLE_W-1:0] out_rd_r;
  logic                out_err_r;

  logic                in_acc;
  logic                out_free;
  logic                idx_bad;
  logic [IDX_W-1:0]    idx_addr;
  logic [IDX_W-1:0]    cell_addr;
  logic [IDX_W-1:0]    cnt_addr;
  logic                row_sat;
  logic [SAMPLE_W:0]   diff;
  logic [PROD_W-1:0]   prod;
  logic [COL_W-1:0]    col_calc;
  logic [RPM_W-1:0]    rpm;
  logic [HOLD_W-1:0]   hold_dec;

  logic                div_start;
  logic [DIV_DW-1:0]   div_dividend;
  logic [DIV_VW-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_DW-1:0]   div_quo;

  tbl_ctl_t            tctl;
  logic [IDX_W-1:0]    log_waddr, log_raddr, cor_waddr, cor_raddr;
  logic [SAMPLE_W-1:0] log_wdata, cor_wdata, log_rdata, cor_rdata;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign idx_bad   = {1'b0, index_r} >= (ENTRY_W + 1)'(TABLE_SIZE);
  assign idx_addr  = index_r[IDX_W-1:0];
  assign cnt_addr  = cnt_r[IDX_W-1:0];
  assign cell_addr = IDX_W'(row_r * THROTTLE_COLS) + IDX_W'(col_r);
  assign row_sat   = (last_period_r == '0) || (rpm_step_r == '0);
  assign rpm       = RPM_W'(div_quo) * RPM_W'(RPM_SCALE);
  assign hold_dec  = (hold_cnt_r != '0) ? hold_cnt_r - 1'b1 : hold_cnt_r;

  always_comb begin
    diff = {1'b0, sample_r} - (SAMPLE_W + 1)'(min_sample_r);
    if (sample_r < SAMPLE_W'(min_sample_r)) begin
      diff = '0;
    end
    prod     = PROD_W'(diff) * PROD_W'(COL_SCALE);
    col_calc = '0;
    for (int k = 1; k < THROTTLE_COLS; k++) begin
      if (prod >= PROD_W'(k * COL_DIV)) begin
        col_calc = col_calc + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    div_start    = 1'b0;
    div_dividend = capture_rate_r;
    div_divisor  = last_period_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TABLE_SIZE - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
        case (mode_r)
          MODE_CTRL: begin
            if (row_sat) begin
              state_nxt = ST_CELL;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV1;
            end
          end
          MODE_READ_COR, MODE_READ_LOG: begin
            if (!idx_bad) begin
              state_nxt = ST_MEMRD;
            end
          end
          MODE_COPY: begin
            cnt_nxt   = '0;
            state_nxt = ST_COPY;
          end
          default: begin
          end
        endcase
      end
      ST_DIV1: begin
        if (div_done) begin
          if (|rpm[RPM_W-1:SAMPLE_W]) begin
            state_nxt = ST_CELL;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(rpm[SAMPLE_W-1:0]);
            div_divisor  = rpm_step_r;
            state_nxt    = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_nxt = ST_CELL;
        end
      end
      ST_CELL:  state_nxt = ST_COR;
      ST_COR:   state_nxt = ST_FINISH;
      ST_MEMRD: state_nxt = ST_FINISH;
      ST_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TABLE_SIZE)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tctl      = '0;
    log_waddr = cell_addr;
    log_wdata = last_pulse_r;
    log_raddr = idx_addr;
    cor_waddr = idx_addr;
    cor_wdata = sample_r;
    cor_raddr = idx_addr;
    case (state_r)
      ST_CLEAR: begin
        tctl.log_we = 1'b1;
        tctl.cor_we = 1'b1;
        log_waddr   = cnt_addr;
        log_wdata   = '0;
        cor_waddr   = cnt_addr;
        cor_wdata   = '0;
      end
      ST_EXEC: begin
        tctl.cor_we = (mode_r == MODE_WRITE) && !idx_bad;
        tctl.cor_re = (mode_r == MODE_READ_COR) && !idx_bad;
        tctl.log_re = (mode_r == MODE_READ_LOG) && !idx_bad;
      end
      ST_CELL: begin
        tctl.log_we = 1'b1;
        tctl.cor_re = 1'b1;
        cor_raddr   = cell_addr;
      end
      ST_COPY: begin
        tctl.log_re = cnt_r < CNT_W'(TABLE_SIZE);
        log_raddr   = cnt_addr;
        tctl.cor_we = copy_wr_r;
        cor_waddr   = copy_wa_r;
        cor_wdata   = log_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      cnt_r          <= '0;
      copy_wr_r      <= 1'b0;
      min_sample_r   <= MIN_SAMPLE_RST;
      rpm_step_r     <= RPM_STEP_RST;
      capture_rate_r <= CAPTURE_RATE_RST;
      last_period_r  <= '0;
      last_pulse_r   <= '0;
      cor_r          <= '0;
      hold_cnt_r     <= '0;
      hold_r         <= 1'b0;
      drive_r        <= 1'b0;
      row_r          <= '0;
      col_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      copy_wr_r <= (state_r == ST_COPY) && tctl.log_re;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_SAMPLE:   min_sample_r   <= cfg_data[MIN_W-1:0];
          CFG_RPM_STEP:     rpm_step_r     <= cfg_data[STEP_W-1:0];
          CFG_CAPTURE_RATE: capture_rate_r <= cfg_data[RATE_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        ST_EXEC: begin
          case (mode_r)
            MODE_RISE: begin
              drive_r       <= 1'b1;
              last_period_r <= sample_r;
            end
            MODE_FALL: begin
              if (cor_r == '0) begin
                drive_r <= 1'b0;
              end else begin
                hold_cnt_r <= {1'b0, cor_r} + 1'b1;
                hold_r     <= 1'b1;
              end
              last_pulse_r <= sample_r;
            end
            MODE_TICK: begin
              if (hold_r) begin
                hold_cnt_r <= hold_dec;
                if (hold_dec == '0) begin
                  drive_r <= 1'b0;
                  hold_r  <= 1'b0;
                end
              end
            end
            MODE_CTRL: begin
              col_r <= col_calc;
              if (row_sat) begin
                row_r <= ROW_W'(RPM_ROWS - 1);
              end
            end
            default: begin
            end
          endcase
        end
        ST_DIV1: begin
          if (div_done && |rpm[RPM_W-1:SAMPLE_W]) begin
            row_r <= ROW_W'(RPM_ROWS - 1);
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            if (div_quo >= DIV_DW'(RPM_ROWS)) begin
              row_r <= ROW_W'(RPM_ROWS - 1);
            end else begin
              row_r <= div_quo[ROW_W-1:0];
            end
          end
        end
        ST_COR: cor_r <= cor_rdata;
        default: begin
        end
      endcase

      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_wa_r <= cnt_addr;
    if (in_acc) begin
      mode_r    <= mode_t'(in_mode);
      sample_r  <= in_sample_value;
      index_r   <= in_entry_index;
      rd_data_r <= '0;
      idx_err_r <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      if ((mode_r == MODE_WRITE || mode_r == MODE_READ_COR || mode_r == MODE_READ_LOG)
          && idx_bad) begin
        idx_err_r <= 1'b1;
      end
    end else if (state_r == ST_MEMRD) begin
      rd_data_r <= (mode_r == MODE_READ_COR) ? cor_rdata : log_rdata;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_on_r   <= drive_r;
      out_hold_r <= hold_r;
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_cor_r  <= cor_r;
      out_rd_r   <= rd_data_r;
      out_err_r  <= idx_err_r;
    end
  end

  imp_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  imp_tables #(
    .DEPTH(TABLE_SIZE),
    .AW   (IDX_W)
  ) u_tables (
    .clk       (clk),
    .ctl       (tctl),
    .log_waddr (log_waddr),
    .log_wdata (log_wdata),
    .log_raddr (log_raddr),
    .log_rdata (log_rdata),
    .cor_waddr (cor_waddr),
    .cor_wdata (cor_wdata),
    .cor_raddr (cor_raddr),
    .cor_rdata (cor_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_injector_on     = out_on_r;
  assign out_override_active = out_hold_r;
  assign out_rpm_row         = out_row_r;
  assign out_throttle_col    = out_col_r;
  assign out_correction_now  = out_cor_r;
  assign out_read_data       = out_rd_r;
  assign out_index_error     = out_err_r;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EXEC)
    else $error("accepted beat did not start execution");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_W'(RPM_ROWS)) && (col_r < COL_W'(THROTTLE_COLS)))
    else $error("row or column outside table");

  a_hold_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(hold_r) && $past(rst_n)) |-> $past(state_r == ST_EXEC && mode_r == MODE_TICK))
    else $error("hold ended without a timer tick");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && $past(rst_n)) |-> $past(state_r == ST_FINISH))
    else $error("result beat raised outside finish");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider finished with no step waiting");
`endif

endmodule
